// ===== rtl/afsd_pkg.sv =====
// Shared types and constants for the frame stream decoder
package afsd_pkg;

    localparam logic [31:0] FRAME_LIMIT_RESET = 32'd4096;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam logic [7:0]  END_OCTET = 8'hCE;
    localparam logic [7:0]  TYPE_METHOD = 8'd1;
    localparam logic [7:0]  TYPE_HEADER = 8'd2;
    localparam logic [7:0]  TYPE_BODY = 8'd3;
    localparam logic [15:0] CLASS_BASIC = 16'd60;
    localparam logic [15:0] METHOD_PUBLISH = 16'd40;
    localparam logic [15:0] METHOD_DELIVER = 16'd60;
    // Index of the seventh and last byte of a frame header
    localparam logic [31:0] HDR_LAST = 32'd6;

    typedef enum logic [1:0]
    {
        REG_SERVER_MODE = 2'd0,
        REG_FLOW_ENABLE = 2'd1,
        REG_FRAME_LIMIT = 2'd2,
        REG_SPARE       = 2'd3
    } reg_index_t;

    typedef enum logic [2:0]
    {
        KIND_NONE     = 3'd0,
        KIND_ARG      = 3'd1,
        KIND_CMD_END  = 3'd2,
        KIND_BODY     = 3'd3,
        KIND_MSG_DONE = 3'd4,
        KIND_ERROR    = 3'd5
    } kind_t;

    typedef enum logic [3:0]
    {
        ERR_METHOD_TYPE = 4'd0,
        ERR_TOO_LARGE   = 4'd1,
        ERR_SHORT       = 4'd2,
        ERR_END_OCTET   = 4'd3,
        ERR_FLOW_OFF    = 4'd4,
        ERR_HDR_TYPE    = 4'd5,
        ERR_HDR_CLASS   = 4'd6,
        ERR_BODY_TYPE   = 4'd7,
        ERR_OVERRUN     = 4'd8
    } err_t;

    typedef enum logic [2:0]
    {
        PH_MHDR = 3'd0,
        PH_MPAY = 3'd1,
        PH_CHDR = 3'd2,
        PH_CPAY = 3'd3,
        PH_BHDR = 3'd4,
        PH_BDAT = 3'd5,
        PH_BEND = 3'd6
    } phase_t;

    // Byte handed from the front to the back
    typedef struct packed
    {
        logic [7:0] data;
    } token_t;

    typedef struct packed
    {
        kind_t       kind;
        logic [7:0]  data;
        logic [15:0] class_no;
        logic [15:0] method_no;
        logic [31:0] arg_count;
        err_t        error_code;
    } result_t;

endpackage

// ===== rtl/afsd_stream_if.sv =====
// Valid/ready channel interfaces for the decoder
interface afsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface afsd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_kind;
    logic [7:0]  out_byte;
    logic [15:0] out_class;
    logic [15:0] out_method;
    logic [31:0] arg_count;
    logic [3:0]  error_code;
    modport source (output valid, output out_kind, output out_byte, output out_class,
                    output out_method, output arg_count, output error_code, input ready);
    modport sink (input valid, input out_kind, input out_byte, input out_class,
                  input out_method, input arg_count, input error_code, output ready);
endinterface

// ===== rtl/afsd_queue.sv =====
// Small token queue between the front and back parts
module afsd_queue #(
    parameter int unsigned DEPTH = afsd_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  afsd_pkg::token_t push_data,
    output logic             full,
    input  logic             pop,
    output afsd_pkg::token_t pop_data,
    output logic             empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    afsd_pkg::token_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

// ===== rtl/afsd_front.sv =====
// Front part: takes bytes and pushes them into the queue
module afsd_front (
    afsd_in_if.sink          in_ch,
    input  logic             q_full,
    output logic             q_push,
    output afsd_pkg::token_t q_data
);
    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;
    assign q_data.data = in_ch.in_byte;
endmodule

// ===== rtl/afsd_back.sv =====
// Back part: frame state machine and result register
module afsd_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             server_mode,
    input  logic             flow_enable,
    input  logic [31:0]      frame_limit,
    input  logic             q_empty,
    input  afsd_pkg::token_t q_data,
    output logic             q_pop,
    afsd_out_if.source       out_ch
);
    afsd_pkg::phase_t phase_reg, phase_next;
    logic [55:0] hdr_reg, hdr_next;
    logic [31:0] cnt_reg, cnt_next, len_reg, len_next;
    logic [15:0] cls_reg, cls_next, mth_reg, mth_next;
    logic [63:0] total_reg, total_next, offs_reg, offs_next;
    logic        halted_reg, halted_next;
    afsd_pkg::result_t res_reg, res_next;
    logic        res_valid_reg;
    logic        go;
    logic [55:0] hdr_shifted;
    logic [7:0]  b;
    logic [7:0]  ftype;
    logic [31:0] fsize;
    logic        too_large, is_start, overrun;
    logic [63:0] remain;

    assign go    = !q_empty && (!res_valid_reg || out_ch.ready);
    assign q_pop = go;
    assign b     = q_data.data;
    assign hdr_shifted = {hdr_reg[47:0], b};
    assign ftype = hdr_shifted[55:48];
    assign fsize = hdr_shifted[31:0];
    assign too_large = ({1'b0, fsize} + 33'd1) > {1'b0, frame_limit};
    assign remain = total_reg - offs_reg;
    assign overrun = {32'd0, fsize} > remain;
    assign is_start = (cls_reg == afsd_pkg::CLASS_BASIC) &&
        (mth_reg == (server_mode ? afsd_pkg::METHOD_PUBLISH : afsd_pkg::METHOD_DELIVER));

    always_comb
    begin
        phase_next  = phase_reg;
        hdr_next    = hdr_reg;
        cnt_next    = cnt_reg;
        len_next    = len_reg;
        cls_next    = cls_reg;
        mth_next    = mth_reg;
        total_next  = total_reg;
        offs_next   = offs_reg;
        halted_next = halted_reg;
        res_next    = '0;
        res_next.kind = afsd_pkg::KIND_NONE;
        res_next.error_code = afsd_pkg::ERR_METHOD_TYPE;
        if (!halted_reg)
        begin
            unique case (phase_reg)
                afsd_pkg::PH_MHDR, afsd_pkg::PH_CHDR, afsd_pkg::PH_BHDR:
                begin
                    hdr_next = hdr_shifted;
                    if (cnt_reg != afsd_pkg::HDR_LAST)
                    begin
                        cnt_next = cnt_reg + 32'd1;
                    end
                    else
                    begin
                        cnt_next = '0;
                        priority if (phase_reg == afsd_pkg::PH_MHDR)
                        begin
                            cls_next = '0;
                            mth_next = '0;
                            if (ftype != afsd_pkg::TYPE_METHOD)
                            begin
                                halted_next = 1'b1;
                                res_next.kind = afsd_pkg::KIND_ERROR;
                                res_next.error_code = afsd_pkg::ERR_METHOD_TYPE;
                            end
                            else if (too_large)
                            begin
                                halted_next = 1'b1;
                                res_next.kind = afsd_pkg::KIND_ERROR;
                                res_next.error_code = afsd_pkg::ERR_TOO_LARGE;
                            end
                            else
                            begin
                                len_next = fsize;
                                phase_next = afsd_pkg::PH_MPAY;
                            end
                        end
                        else if (phase_reg == afsd_pkg::PH_CHDR)
                        begin
                            if (ftype != afsd_pkg::TYPE_HEADER)
                            begin
                                halted_next = 1'b1;
                                res_next.kind = afsd_pkg::KIND_ERROR;
                                res_next.error_code = afsd_pkg::ERR_HDR_TYPE;
                            end
                            else if (too_large)
                            begin
                                halted_next = 1'b1;
                                res_next.kind = afsd_pkg::KIND_ERROR;
                                res_next.error_code = afsd_pkg::ERR_TOO_LARGE;
                            end
                            else
                            begin
                                len_next = fsize;
                                hdr_next = '0;
                                total_next = '0;
                                phase_next = afsd_pkg::PH_CPAY;
                            end
                        end
                        else
                        begin
                            if (ftype != afsd_pkg::TYPE_BODY)
                            begin
                                halted_next = 1'b1;
                                res_next.kind = afsd_pkg::KIND_ERROR;
                                res_next.error_code = afsd_pkg::ERR_BODY_TYPE;
                            end
                            else if (overrun)
                            begin
                                halted_next = 1'b1;
                                res_next.kind = afsd_pkg::KIND_ERROR;
                                res_next.error_code = afsd_pkg::ERR_OVERRUN;
                            end
                            else
                            begin
                                len_next = fsize;
                                phase_next = (fsize != '0) ? afsd_pkg::PH_BDAT
                                                           : afsd_pkg::PH_BEND;
                            end
                        end
                    end
                end
                afsd_pkg::PH_MPAY:
                begin
                    if (cnt_reg < len_reg)
                    begin
                        cnt_next = cnt_reg + 32'd1;
                        if (cnt_reg < 32'd2)
                        begin
                            cls_next = {cls_reg[7:0], b};
                        end
                        else if (cnt_reg < 32'd4)
                        begin
                            mth_next = {mth_reg[7:0], b};
                        end
                        else if (!is_start)
                        begin
                            res_next.kind = afsd_pkg::KIND_ARG;
                            res_next.data = b;
                        end
                    end
                    else
                    begin
                        cnt_next = '0;
                        if (len_reg < 32'd4)
                        begin
                            halted_next = 1'b1;
                            res_next.kind = afsd_pkg::KIND_ERROR;
                            res_next.error_code = afsd_pkg::ERR_SHORT;
                        end
                        else if (b != afsd_pkg::END_OCTET)
                        begin
                            halted_next = 1'b1;
                            res_next.kind = afsd_pkg::KIND_ERROR;
                            res_next.error_code = afsd_pkg::ERR_END_OCTET;
                        end
                        else if (is_start)
                        begin
                            if (!flow_enable)
                            begin
                                halted_next = 1'b1;
                                res_next.kind = afsd_pkg::KIND_ERROR;
                                res_next.error_code = afsd_pkg::ERR_FLOW_OFF;
                            end
                            else
                            begin
                                phase_next = afsd_pkg::PH_CHDR;
                                hdr_next = '0;
                            end
                        end
                        else
                        begin
                            phase_next = afsd_pkg::PH_MHDR;
                            hdr_next = '0;
                            res_next.kind = afsd_pkg::KIND_CMD_END;
                            res_next.arg_count = len_reg - 32'd4;
                        end
                    end
                end
                afsd_pkg::PH_CPAY:
                begin
                    if (cnt_reg < len_reg)
                    begin
                        cnt_next = cnt_reg + 32'd1;
                        if (cnt_reg < 32'd2)
                        begin
                            hdr_next = {40'd0, hdr_reg[7:0], b};
                        end
                        else if (cnt_reg >= 32'd4 && cnt_reg < 32'd12)
                        begin
                            total_next = {total_reg[55:0], b};
                        end
                    end
                    else
                    begin
                        cnt_next = '0;
                        if (len_reg < 32'd12)
                        begin
                            halted_next = 1'b1;
                            res_next.kind = afsd_pkg::KIND_ERROR;
                            res_next.error_code = afsd_pkg::ERR_SHORT;
                        end
                        else if (hdr_reg[15:0] != afsd_pkg::CLASS_BASIC)
                        begin
                            halted_next = 1'b1;
                            res_next.kind = afsd_pkg::KIND_ERROR;
                            res_next.error_code = afsd_pkg::ERR_HDR_CLASS;
                        end
                        else if (b != afsd_pkg::END_OCTET)
                        begin
                            halted_next = 1'b1;
                            res_next.kind = afsd_pkg::KIND_ERROR;
                            res_next.error_code = afsd_pkg::ERR_END_OCTET;
                        end
                        else
                        begin
                            offs_next = '0;
                            hdr_next = '0;
                            phase_next = afsd_pkg::PH_BHDR;
                        end
                    end
                end
                afsd_pkg::PH_BDAT:
                begin
                    offs_next = offs_reg + 64'd1;
                    cnt_next = cnt_reg + 32'd1;
                    if (cnt_next >= len_reg)
                    begin
                        cnt_next = '0;
                        phase_next = afsd_pkg::PH_BEND;
                    end
                    res_next.kind = afsd_pkg::KIND_BODY;
                    res_next.data = b;
                end
                default:
                begin
                    cnt_next = '0;
                    hdr_next = '0;
                    if (b != afsd_pkg::END_OCTET)
                    begin
                        halted_next = 1'b1;
                        res_next.kind = afsd_pkg::KIND_ERROR;
                        res_next.error_code = afsd_pkg::ERR_END_OCTET;
                    end
                    else if (offs_reg == total_reg)
                    begin
                        phase_next = afsd_pkg::PH_MHDR;
                        res_next.kind = afsd_pkg::KIND_MSG_DONE;
                    end
                    else
                    begin
                        phase_next = afsd_pkg::PH_BHDR;
                    end
                end
            endcase
        end
        // Ids on the result include this byte's update
        res_next.class_no  = cls_next;
        res_next.method_no = mth_next;
    end

    assign out_ch.valid      = res_valid_reg;
    assign out_ch.out_kind   = res_reg.kind;
    assign out_ch.out_byte   = res_reg.data;
    assign out_ch.out_class  = res_reg.class_no;
    assign out_ch.out_method = res_reg.method_no;
    assign out_ch.arg_count  = res_reg.arg_count;
    assign out_ch.error_code = res_reg.error_code;

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= afsd_pkg::PH_MHDR;
            hdr_reg       <= '0;
            cnt_reg       <= '0;
            len_reg       <= '0;
            cls_reg       <= '0;
            mth_reg       <= '0;
            total_reg     <= '0;
            offs_reg      <= '0;
            halted_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                phase_reg  <= phase_next;
                hdr_reg    <= hdr_next;
                cnt_reg    <= cnt_next;
                len_reg    <= len_next;
                cls_reg    <= cls_next;
                mth_reg    <= mth_next;
                total_reg  <= total_next;
                offs_reg   <= offs_next;
                halted_reg <= halted_next;
                res_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end
endmodule

// ===== rtl/amqp_frame_stream_decoder.sv =====
// Top level of the AMQP 0-9 frame stream decoder
// One received byte per transfer in, exactly one result per byte out, at one byte per
// cycle sustained while the output is ready. A byte passes the front, then a two-entry
// queue, then the back state machine, which counts frame header bytes and registers the
// result: a byte is first stored in the queue and its result then in the result register.
// After any error the block gives kind 0 for every byte until reset.
module amqp_frame_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = afsd_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    afsd_in_if.sink     in_ch,
    afsd_out_if.source  out_ch
);
    logic        server_mode_reg, flow_enable_reg;
    logic [31:0] frame_limit_reg;
    logic        q_push, q_pop, q_full, q_empty;
    afsd_pkg::token_t q_in, q_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_mode_reg <= 1'b0;
            flow_enable_reg <= 1'b0;
            frame_limit_reg <= afsd_pkg::FRAME_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (afsd_pkg::reg_index_t'(cfg_index))
                afsd_pkg::REG_SERVER_MODE: server_mode_reg <= cfg_data[0];
                afsd_pkg::REG_FLOW_ENABLE: flow_enable_reg <= cfg_data[0];
                afsd_pkg::REG_FRAME_LIMIT: frame_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    afsd_front u_front (
        .in_ch     (in_ch),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    afsd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    afsd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .server_mode (server_mode_reg),
        .flow_enable (flow_enable_reg),
        .frame_limit (frame_limit_reg),
        .q_empty     (q_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .out_ch      (out_ch)
    );
endmodule

// ===== bench/amqp_frame_stream_decoder_tb.sv =====
// Self-checking bench for the AMQP 0-9 frame stream decoder: frame stimulus and scoreboard
module amqp_frame_stream_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 500;

    // Predicts the result of every accepted byte and holds the results still owed
    class decode_scoreboard;
        bit                 server;
        bit                 flow;
        logic [31:0]        limit;
        afsd_pkg::phase_t   ph;
        logic [55:0]        hdr_bytes;
        logic [31:0]        cnt;
        logic [31:0]        plen;
        logic [15:0]        cls;
        logic [15:0]        mth;
        logic [63:0]        body_total;
        logic [63:0]        body_seen;
        bit                 halted;
        afsd_pkg::result_t  owed_q[$];
        int                 fails;

        function new();
            server = 0;
            flow = 0;
            limit = afsd_pkg::FRAME_LIMIT_RESET;
            ph = afsd_pkg::PH_MHDR;
            hdr_bytes = '0;
            cnt = '0;
            plen = '0;
            cls = '0;
            mth = '0;
            body_total = '0;
            body_seen = '0;
            halted = 0;
            fails = 0;
        endfunction

        function void set_reg(afsd_pkg::reg_index_t idx, logic [31:0] v);
            case (idx)
                afsd_pkg::REG_SERVER_MODE: server = v[0];
                afsd_pkg::REG_FLOW_ENABLE: flow = v[0];
                afsd_pkg::REG_FRAME_LIMIT: limit = v;
                default: ;
            endcase
        endfunction

        function afsd_pkg::result_t fill(afsd_pkg::kind_t k, logic [7:0] d, logic [31:0] c,
                                         afsd_pkg::err_t e);
            afsd_pkg::result_t r;
            r.kind = k;
            r.data = d;
            r.class_no = cls;
            r.method_no = mth;
            r.arg_count = c;
            r.error_code = e;
            return r;
        endfunction

        function afsd_pkg::result_t fail(afsd_pkg::err_t e);
            halted = 1;
            return fill(afsd_pkg::KIND_ERROR, 8'd0, 32'd0, e);
        endfunction

        function afsd_pkg::result_t none();
            return fill(afsd_pkg::KIND_NONE, 8'd0, 32'd0, afsd_pkg::ERR_METHOD_TYPE);
        endfunction

        function bit is_start();
            return cls == afsd_pkg::CLASS_BASIC &&
                   mth == (server ? afsd_pkg::METHOD_PUBLISH : afsd_pkg::METHOD_DELIVER);
        endfunction

        function afsd_pkg::result_t decode(logic [7:0] b);
            logic [7:0]  ftype;
            logic [31:0] fsize;
            logic [31:0] idx;
            if (halted)
                return none();
            if (ph == afsd_pkg::PH_MHDR || ph == afsd_pkg::PH_CHDR || ph == afsd_pkg::PH_BHDR)
            begin
                hdr_bytes = {hdr_bytes[47:0], b};
                cnt++;
                if (cnt < 7)
                    return none();
                cnt = 0;
                ftype = hdr_bytes[55:48];
                fsize = hdr_bytes[31:0];
                if (ph == afsd_pkg::PH_MHDR)
                begin
                    cls = '0;
                    mth = '0;
                    if (ftype != afsd_pkg::TYPE_METHOD)
                        return fail(afsd_pkg::ERR_METHOD_TYPE);
                    if ({1'b0, fsize} + 33'd1 > {1'b0, limit})
                        return fail(afsd_pkg::ERR_TOO_LARGE);
                    plen = fsize;
                    ph = afsd_pkg::PH_MPAY;
                end
                else if (ph == afsd_pkg::PH_CHDR)
                begin
                    if (ftype != afsd_pkg::TYPE_HEADER)
                        return fail(afsd_pkg::ERR_HDR_TYPE);
                    if ({1'b0, fsize} + 33'd1 > {1'b0, limit})
                        return fail(afsd_pkg::ERR_TOO_LARGE);
                    plen = fsize;
                    hdr_bytes = '0;
                    body_total = '0;
                    ph = afsd_pkg::PH_CPAY;
                end
                else
                begin
                    if (ftype != afsd_pkg::TYPE_BODY)
                        return fail(afsd_pkg::ERR_BODY_TYPE);
                    if ({32'd0, fsize} > body_total - body_seen)
                        return fail(afsd_pkg::ERR_OVERRUN);
                    plen = fsize;
                    ph = (fsize != 0) ? afsd_pkg::PH_BDAT : afsd_pkg::PH_BEND;
                end
                return none();
            end
            if (ph == afsd_pkg::PH_MPAY)
            begin
                idx = cnt;
                if (idx < plen)
                begin
                    cnt++;
                    if (idx < 2)
                        cls = {cls[7:0], b};
                    else if (idx < 4)
                        mth = {mth[7:0], b};
                    else if (!is_start())
                        return fill(afsd_pkg::KIND_ARG, b, 32'd0, afsd_pkg::ERR_METHOD_TYPE);
                    return none();
                end
                cnt = 0;
                if (plen < 4)
                    return fail(afsd_pkg::ERR_SHORT);
                if (b != afsd_pkg::END_OCTET)
                    return fail(afsd_pkg::ERR_END_OCTET);
                hdr_bytes = '0;
                if (is_start())
                begin
                    if (!flow)
                        return fail(afsd_pkg::ERR_FLOW_OFF);
                    ph = afsd_pkg::PH_CHDR;
                    return none();
                end
                ph = afsd_pkg::PH_MHDR;
                return fill(afsd_pkg::KIND_CMD_END, 8'd0, plen - 32'd4,
                            afsd_pkg::ERR_METHOD_TYPE);
            end
            if (ph == afsd_pkg::PH_CPAY)
            begin
                idx = cnt;
                if (idx < plen)
                begin
                    cnt++;
                    if (idx < 2)
                        hdr_bytes = {40'd0, hdr_bytes[7:0], b};
                    else if (idx >= 4 && idx < 12)
                        body_total = {body_total[55:0], b};
                    return none();
                end
                cnt = 0;
                if (plen < 12)
                    return fail(afsd_pkg::ERR_SHORT);
                if (hdr_bytes[15:0] != afsd_pkg::CLASS_BASIC)
                    return fail(afsd_pkg::ERR_HDR_CLASS);
                if (b != afsd_pkg::END_OCTET)
                    return fail(afsd_pkg::ERR_END_OCTET);
                body_seen = '0;
                hdr_bytes = '0;
                ph = afsd_pkg::PH_BHDR;
                return none();
            end
            if (ph == afsd_pkg::PH_BDAT)
            begin
                body_seen++;
                cnt++;
                if (cnt >= plen)
                begin
                    cnt = 0;
                    ph = afsd_pkg::PH_BEND;
                end
                return fill(afsd_pkg::KIND_BODY, b, 32'd0, afsd_pkg::ERR_METHOD_TYPE);
            end
            // end octet of a body frame
            cnt = 0;
            hdr_bytes = '0;
            if (b != afsd_pkg::END_OCTET)
                return fail(afsd_pkg::ERR_END_OCTET);
            if (body_seen == body_total)
            begin
                ph = afsd_pkg::PH_MHDR;
                return fill(afsd_pkg::KIND_MSG_DONE, 8'd0, 32'd0, afsd_pkg::ERR_METHOD_TYPE);
            end
            ph = afsd_pkg::PH_BHDR;
            return none();
        endfunction

        function void note_byte(logic [7:0] b);
            owed_q.push_back(decode(b));
        endfunction

        function void check_result(logic [2:0] k, logic [7:0] d, logic [15:0] c,
                                   logic [15:0] m, logic [31:0] n, logic [3:0] e);
            afsd_pkg::result_t x;
            if (owed_q.size() == 0)
            begin
                $error("result with nothing expected: out_kind %0d", k);
                fails++;
                return;
            end
            x = owed_q.pop_front();
            if (k !== x.kind)
            begin
                $error("out_kind expected %0d actual %0d", x.kind, k);
                fails++;
            end
            if (d !== x.data)
            begin
                $error("out_byte expected %0h actual %0h", x.data, d);
                fails++;
            end
            if (c !== x.class_no)
            begin
                $error("out_class expected %0d actual %0d", x.class_no, c);
                fails++;
            end
            if (m !== x.method_no)
            begin
                $error("out_method expected %0d actual %0d", x.method_no, m);
                fails++;
            end
            if (n !== x.arg_count)
            begin
                $error("arg_count expected %0d actual %0d", x.arg_count, n);
                fails++;
            end
            if (e !== x.error_code)
            begin
                $error("error_code expected %0d actual %0d", x.error_code, e);
                fails++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    afsd_in_if  in_if ();
    afsd_out_if out_if ();

    amqp_frame_stream_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_if),
        .out_ch    (out_if)
    );

    decode_scoreboard sb = new();
    bit  quiet;
    bit  tx_gaps;
    bit  rx_stalls;
    int  stall_left;
    int  bytes_sent;
    int  cycles;

    always #6 clk = ~clk;

    // Take results, stalling the output in bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            out_if.ready <= 0;
        else
        begin
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.out_kind, out_if.out_byte, out_if.out_class,
                                out_if.out_method, out_if.arg_count, out_if.error_code);
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_if.ready <= 0;
            end
            else if (rx_stalls && !quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(0, 6);
                out_if.ready <= 0;
            end
            else
                out_if.ready <= 1;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (tx_gaps && !quiet && $urandom_range(0, 9) == 0)
        begin
            in_if.valid <= 0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_if.valid <= 1;
        in_if.in_byte <= b;
        do
            @(posedge clk);
        while (!in_if.ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    // Hold off until every result is in and the pipeline has emptied
    task automatic drain();
        in_if.valid <= 0;
        while (sb.owed_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic configure(input bit mode, input bit flow, input logic [31:0] lim);
        drain();
        cfg_we <= 1;
        cfg_index <= afsd_pkg::REG_SERVER_MODE;
        cfg_data <= {31'd0, mode};
        @(posedge clk);
        cfg_index <= afsd_pkg::REG_FLOW_ENABLE;
        cfg_data <= {31'd0, flow};
        @(posedge clk);
        cfg_index <= afsd_pkg::REG_FRAME_LIMIT;
        cfg_data <= lim;
        @(posedge clk);
        cfg_we <= 0;
        sb.set_reg(afsd_pkg::REG_SERVER_MODE, {31'd0, mode});
        sb.set_reg(afsd_pkg::REG_FLOW_ENABLE, {31'd0, flow});
        sb.set_reg(afsd_pkg::REG_FRAME_LIMIT, lim);
        tx_gaps = $urandom_range(0, 3) != 0;
        rx_stalls = $urandom_range(0, 3) != 0;
    endtask

    task automatic send_hdr(input logic [7:0] ftype, input logic [31:0] size);
        send_byte(ftype);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        for (int i = 3; i >= 0; i--)
            send_byte(size[i*8 +: 8]);
    endtask

    task automatic send_method(input logic [15:0] c, input logic [15:0] m, input int nargs,
                               input bit extreme);
        send_hdr(afsd_pkg::TYPE_METHOD, nargs + 4);
        send_byte(c[15:8]);
        send_byte(c[7:0]);
        send_byte(m[15:8]);
        send_byte(m[7:0]);
        for (int i = 0; i < nargs; i++)
            send_byte(extreme ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom));
        send_byte(afsd_pkg::END_OCTET);
    endtask

    task automatic send_start(input int nargs);
        send_method(afsd_pkg::CLASS_BASIC,
                    sb.server ? afsd_pkg::METHOD_PUBLISH : afsd_pkg::METHOD_DELIVER, nargs, 0);
    endtask

    task automatic send_content(input logic [63:0] total, input int extra,
                                input logic [15:0] c);
        send_hdr(afsd_pkg::TYPE_HEADER, 12 + extra);
        send_byte(c[15:8]);
        send_byte(c[7:0]);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        for (int i = 7; i >= 0; i--)
            send_byte(total[i*8 +: 8]);
        for (int i = 0; i < extra; i++)
            send_byte(8'($urandom));
        send_byte(afsd_pkg::END_OCTET);
    endtask

    task automatic send_body(input int len);
        send_hdr(afsd_pkg::TYPE_BODY, len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom));
        send_byte(afsd_pkg::END_OCTET);
    endtask

    task automatic send_message(input int total, input int extra);
        int left;
        int chunk;
        left = total;
        send_start($urandom_range(0, 6));
        send_content(64'(total), extra, afsd_pkg::CLASS_BASIC);
        do
        begin
            chunk = (left == 0) ? 0 : $urandom_range(1, (left < 15) ? left : 15);
            send_body(chunk);
            left -= chunk;
        end
        while (left > 0);
    endtask

    // Plain command: never the id pair that starts a message in this mode
    task automatic send_command();
        logic [15:0] c;
        logic [15:0] m;
        c = ($urandom_range(0, 3) == 0) ? afsd_pkg::CLASS_BASIC : 16'($urandom);
        m = ($urandom_range(0, 2) == 0) ? afsd_pkg::METHOD_PUBLISH : 16'($urandom);
        if (c == afsd_pkg::CLASS_BASIC &&
            m == (sb.server ? afsd_pkg::METHOD_PUBLISH : afsd_pkg::METHOD_DELIVER))
            m = sb.server ? afsd_pkg::METHOD_DELIVER : afsd_pkg::METHOD_PUBLISH;
        send_method(c, m, $urandom_range(0, 11), 0);
    endtask

    task automatic send_fault(input afsd_pkg::err_t code);
        send_command();
        case (code)
            afsd_pkg::ERR_METHOD_TYPE: send_hdr(8'd5, 32'd4);
            afsd_pkg::ERR_TOO_LARGE:   send_hdr(afsd_pkg::TYPE_METHOD, 32'hFFFF_FFFF);
            afsd_pkg::ERR_SHORT:
            begin
                send_hdr(afsd_pkg::TYPE_METHOD, 32'd2);
                send_byte(8'($urandom));
                send_byte(8'($urandom));
                send_byte(afsd_pkg::END_OCTET);
            end
            afsd_pkg::ERR_END_OCTET:
            begin
                send_hdr(afsd_pkg::TYPE_METHOD, 32'd4);
                repeat (4) send_byte(8'($urandom));
                send_byte(8'h00);
            end
            afsd_pkg::ERR_FLOW_OFF:    send_start(2);
            afsd_pkg::ERR_HDR_TYPE:
            begin
                send_start(1);
                send_hdr(afsd_pkg::TYPE_METHOD, 32'd12);
            end
            afsd_pkg::ERR_HDR_CLASS:
            begin
                send_start(0);
                send_content(64'd5, 0, afsd_pkg::CLASS_BASIC + 16'd1);
            end
            afsd_pkg::ERR_BODY_TYPE:
            begin
                send_start(0);
                send_content(64'd5, 1, afsd_pkg::CLASS_BASIC);
                send_hdr(afsd_pkg::TYPE_HEADER, 32'd5);
            end
            default:
            begin
                send_start(0);
                send_content(64'd5, 0, afsd_pkg::CLASS_BASIC);
                send_hdr(afsd_pkg::TYPE_BODY, 32'd6);
            end
        endcase
        // halted: everything after gives nothing
        repeat (6) send_byte(8'($urandom));
    endtask

    initial
    begin
        afsd_pkg::err_t fault;
        logic [31:0] lim;
        int target;
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = afsd_pkg::REG_SERVER_MODE;
        cfg_data = '0;
        in_if.valid = 0;
        in_if.in_byte = '0;
        quiet = 0;
        tx_gaps = 1;
        rx_stalls = 1;
        bytes_sent = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset settings: publish ids are a plain command in client mode
        send_method(afsd_pkg::CLASS_BASIC, afsd_pkg::METHOD_PUBLISH, 2, 1);
        // smallest frame limit, zero body size, extra content header bytes
        configure(1, 1, 32'd16);
        send_start(0);
        send_content(64'd0, 3, afsd_pkg::CLASS_BASIC);
        send_body(0);

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: lim = 32'hFFFF_FFFF;
                1: lim = 32'd16;
                default: lim = $urandom_range(16, 5000);
            endcase
            configure($urandom_range(0, 1), p != 2, lim);
            target = bytes_sent + RANDOM_ITEMS / 5;
            while (bytes_sent < target)
            begin
                if (sb.flow && $urandom_range(0, 9) < 4)
                    send_message(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 40),
                                 $urandom_range(0, 3));
                else
                    send_command();
            end
        end

        // last part: no idling, then one fault that halts the block
        drain();
        quiet = 1;
        fault = afsd_pkg::err_t'($urandom_range(afsd_pkg::ERR_METHOD_TYPE,
                                                afsd_pkg::ERR_OVERRUN));
        configure($urandom_range(0, 1), fault != afsd_pkg::ERR_FLOW_OFF,
                  (fault == afsd_pkg::ERR_TOO_LARGE) ? 32'hFFFF_FFFF
                                                     : afsd_pkg::FRAME_LIMIT_RESET);
        send_fault(fault);
        drain();
        if (sb.fails == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
